FILE: hw/rtl/msp_pkg.sv
package msp_pkg;

    // Number of servo outputs served in one frame.
    localparam int NUM_SERVOS = 8;
    // Bits needed to address one servo.
    localparam int SLOT_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

    // Payload widths fixed by the interface.
    localparam int FUNC_W    = 2;
    localparam int CHANNEL_W = 4;
    localparam int POS_W     = 8;
    localparam int PINS_W    = 8;
    localparam int TICKS_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    // Register reset values.
    localparam logic [TICKS_W-1:0] FRAME_TICKS_RST = 12'd1152;
    localparam logic [POS_W-1:0]   MIN_HIGH_RST    = 8'd1;
    localparam logic [POS_W-1:0]   MAX_HIGH_RST    = 8'd255;

    // Operation codes of an input beat.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK = 2'd0,
        FUNC_SET  = 2'd1,
        FUNC_GET  = 2'd2
    } func_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_TICKS = 2'd0,
        CFG_MIN_HIGH    = 2'd1,
        CFG_MAX_HIGH    = 2'd2
    } cfg_idx_t;

    // Configuration values as seen by the pulse engine.
    typedef struct packed {
        logic [TICKS_W-1:0] frame_ticks;
        logic [POS_W-1:0]   min_high;
        logic [POS_W-1:0]   max_high;
    } cfg_t;

endpackage

FILE: hw/rtl/msp_if.sv
// Input channel: one command beat.
interface msp_item_if;
    logic                           valid;
    logic                           ready;
    logic [msp_pkg::FUNC_W-1:0]     func;
    logic [msp_pkg::CHANNEL_W-1:0]  channel;
    logic [msp_pkg::POS_W-1:0]      position;

    modport source (output valid, output func, output channel, output position, input ready);
    modport sink (input valid, input func, input channel, input position, output ready);
endinterface

// Result channel: one result beat per command.
interface msp_result_if;
    logic                           valid;
    logic                           ready;
    logic [msp_pkg::PINS_W-1:0]     pins;
    logic [msp_pkg::POS_W-1:0]      read_position;

    modport source (output valid, output pins, output read_position, input ready);
    modport sink (input valid, input pins, input read_position, output ready);
endinterface

// Configuration write channel.
interface msp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [msp_pkg::CFG_IDX_W-1:0]    index;
    logic [msp_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/msp_ram.sv
module msp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    output logic [WIDTH-1:0]                            rdata_a,
    input  logic                                        re_b,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                            rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, two registered read ports; a read in the same cycle
    // as a write to that address returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: hw/rtl/msp_cfg_regs.sv
module msp_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    msp_cfg_if.sink           cfg,
    output msp_pkg::cfg_t     cfg_values
);

    msp_pkg::cfg_t cfg_reg;
    msp_pkg::cfg_t cfg_next;

    // Writes are always taken; an unknown index leaves every register alone.
    assign cfg.ready  = 1'b1;
    assign cfg_values = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                msp_pkg::CFG_FRAME_TICKS: cfg_next.frame_ticks = cfg.data;
                msp_pkg::CFG_MIN_HIGH:    cfg_next.min_high = cfg.data[msp_pkg::POS_W-1:0];
                msp_pkg::CFG_MAX_HIGH:    cfg_next.max_high = cfg.data[msp_pkg::POS_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_ticks <= msp_pkg::FRAME_TICKS_RST;
            cfg_reg.min_high    <= msp_pkg::MIN_HIGH_RST;
            cfg_reg.max_high    <= msp_pkg::MAX_HIGH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hw/rtl/msp_engine.sv
module msp_engine (
    input  logic              clk,
    input  logic              rst_n,
    msp_item_if.sink          item,
    msp_result_if.source      result,
    input  msp_pkg::cfg_t     cfg_values
);

    localparam int SW = msp_pkg::SLOT_W;
    localparam int NS = msp_pkg::NUM_SERVOS;
    localparam int PW = msp_pkg::POS_W;
    localparam int TW = msp_pkg::TICKS_W;

    // Flow control: input stage and result register.
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic accept;
    logic proc;

    // Input stage payload.
    logic [msp_pkg::FUNC_W-1:0]    s1_func_reg;
    logic [msp_pkg::CHANNEL_W-1:0] s1_channel_reg;
    logic [PW-1:0]                 s1_pos_reg;
    logic                          a_fwd_reg;
    logic [PW-1:0]                 a_fwd_data_reg;
    logic                          a_vld_reg;

    // Slot-load read port bookkeeping.
    logic                          b_fwd_reg;
    logic [PW-1:0]                 b_fwd_data_reg;
    logic                          b_vld_reg;
    logic [SW-1:0]                 b_addr;

    // Frame sequencer state.
    logic [SW-1:0] slot_reg, slot_next;
    logic          in_idle_reg, in_idle_next;
    logic [TW-1:0] ticks_left_reg, ticks_left_next;
    logic [TW-1:0] high_sum_reg, high_sum_next;

    // Per-servo written and nonzero flags.
    logic [NS-1:0] vld_reg, vld_next;
    logic [NS-1:0] nz_reg, nz_next;

    // Result register.
    logic [msp_pkg::PINS_W-1:0] pins_reg;
    logic [PW-1:0]              rd_reg;

    // Store write port.
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic [PW-1:0] wr_data;

    logic [PW-1:0] ram_a;
    logic [PW-1:0] ram_b;
    logic [PW-1:0] get_data;
    logic [PW-1:0] load_data;
    logic [PW-1:0] clamped;
    logic          s1_ch_ok;
    logic [SW:0]   slot_inc;
    logic [msp_pkg::PINS_W-1:0] pins_now;
    logic [PW-1:0] rd_now;
    logic [SW-1:0] in_addr;

    assign proc        = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready  = !s1_valid_reg || proc;
    assign accept      = item.valid && item.ready;
    assign in_addr     = item.channel[SW-1:0];

    assign result.valid         = out_valid_reg;
    assign result.pins          = pins_reg;
    assign result.read_position = rd_reg;

    msp_ram #(
        .WIDTH (PW),
        .DEPTH (NS)
    ) u_store (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .re_a    (accept),
        .raddr_a (in_addr),
        .rdata_a (ram_a),
        .re_b    (1'b1),
        .raddr_b (b_addr),
        .rdata_b (ram_b)
    );

    // Store data as seen by the item in the input stage, with the write of
    // the same edge forwarded and never-written entries reading as zero.
    assign get_data  = a_fwd_reg ? a_fwd_data_reg : (a_vld_reg ? ram_a : '0);
    assign load_data = b_fwd_reg ? b_fwd_data_reg : (b_vld_reg ? ram_b : '0);

    // Clamp a nonzero set value into the configured window.
    always_comb
    begin
        clamped = s1_pos_reg;
        if (s1_pos_reg != '0)
        begin
            if (s1_pos_reg < cfg_values.min_high)
            begin
                clamped = cfg_values.min_high;
            end
            else if (s1_pos_reg > cfg_values.max_high)
            begin
                clamped = cfg_values.max_high;
            end
        end
    end

    assign s1_ch_ok = s1_channel_reg < msp_pkg::CHANNEL_W'(NS);
    assign wr_en    = proc && (s1_func_reg == msp_pkg::FUNC_SET) && s1_ch_ok;
    assign wr_addr  = s1_channel_reg[SW-1:0];
    assign wr_data  = clamped;

    // Pin levels during the present tick.
    assign pins_now = (!in_idle_reg && nz_reg[slot_reg])
                      ? (msp_pkg::PINS_W'(1) << slot_reg) : '0;
    assign rd_now   = ((s1_func_reg == msp_pkg::FUNC_GET) && s1_ch_ok) ? get_data : '0;

    // Frame sequencer: count down the segment, then load the next slot or idle.
    assign slot_inc = (SW + 1)'(slot_reg) + (SW + 1)'(1);

    always_comb
    begin
        slot_next       = slot_reg;
        in_idle_next    = in_idle_reg;
        ticks_left_next = ticks_left_reg;
        high_sum_next   = high_sum_reg;
        if (proc && (s1_func_reg == msp_pkg::FUNC_TICK))
        begin
            if (ticks_left_reg != '0)
            begin
                ticks_left_next = ticks_left_reg - TW'(1);
            end
            else if (in_idle_reg)
            begin
                in_idle_next    = 1'b0;
                slot_next       = '0;
                ticks_left_next = TW'(load_data);
                high_sum_next   = TW'(load_data);
            end
            else if (slot_inc < (SW + 1)'(NS))
            begin
                slot_next       = slot_inc[SW-1:0];
                ticks_left_next = TW'(load_data);
                high_sum_next   = high_sum_reg + TW'(load_data);
            end
            else
            begin
                in_idle_next    = 1'b1;
                slot_next       = '0;
                ticks_left_next = (cfg_values.frame_ticks > high_sum_reg)
                                  ? (cfg_values.frame_ticks - high_sum_reg) : '0;
            end
        end
    end

    // Prefetch the entry that the next segment end will load.
    assign b_addr = in_idle_next ? '0 : (slot_next + SW'(1));

    // Flags per servo follow the store writes.
    always_comb
    begin
        vld_next = vld_reg;
        nz_next  = nz_reg;
        if (wr_en)
        begin
            vld_next[wr_addr] = 1'b1;
            nz_next[wr_addr]  = (wr_data != '0);
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (proc)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_reg       <= '0;
            in_idle_reg    <= 1'b0;
            ticks_left_reg <= '0;
            high_sum_reg   <= '0;
            vld_reg        <= '0;
            nz_reg         <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            slot_reg       <= slot_next;
            in_idle_reg    <= in_idle_next;
            ticks_left_reg <= ticks_left_next;
            high_sum_reg   <= high_sum_next;
            vld_reg        <= vld_next;
            nz_reg         <= nz_next;
        end
    end

    // Input stage payload and the matching store read bookkeeping.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg    <= item.func;
            s1_channel_reg <= item.channel;
            s1_pos_reg     <= item.position;
            a_fwd_reg      <= wr_en && (wr_addr == in_addr);
            a_fwd_data_reg <= wr_data;
            a_vld_reg      <= vld_reg[in_addr];
        end
        b_fwd_reg      <= wr_en && (wr_addr == b_addr);
        b_fwd_data_reg <= wr_data;
        b_vld_reg      <= vld_reg[b_addr];
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            pins_reg <= pins_now;
            rd_reg   <= rd_now;
        end
    end

endmodule

FILE: hw/rtl/multiplexed_servo_pulse_generator.sv
// Multiplexed servo pulse generator.
// The item channel carries one command per beat: func selects a tick, a set
// of one servo's position, or a get of a stored position. Every command beat
// yields exactly one result beat on the result channel, carrying the pin
// levels that held during that command and, for a get, the stored position.
// Servos are served one after another in a frame; each slot lasts position+1
// ticks; pins then stay low for max(frame_ticks - position sum, 0) + 1 ticks.
// The cfg channel writes frame_ticks, min_high and max_high; it is always
// ready and should be used only while no command is in flight.
// Throughput is one command per cycle while the result receiver keeps up.
// An accepted command moves from the input register into the result register
// once the result register is free or its beat is being taken.
// Reset marks every position store entry unwritten (read as zero), clears the
// frame sequencer and both pipeline registers, and loads register defaults.
// When the result receiver stalls, one result waits in the result register
// while one more command is held in the input register; item.ready then drops
// until the waiting result is taken.
module multiplexed_servo_pulse_generator (
    input  logic          clk,
    input  logic          rst_n,
    msp_item_if.sink      item,
    msp_result_if.source  result,
    msp_cfg_if.sink       cfg
);

    msp_pkg::cfg_t cfg_values;

    // Configuration registers.
    msp_cfg_regs u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_values (cfg_values)
    );

    // Command pipeline, position store and frame sequencer.
    msp_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .cfg_values (cfg_values)
    );

endmodule

FILE: dv/multiplexed_servo_pulse_generator_test.sv
module multiplexed_servo_pulse_generator_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 4;
    localparam int DRAIN_CYCLES   = 6;
    localparam int LONG_HOLD      = 300;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int REPORT_LIMIT   = 10;

    // Codes that the block must treat as no-ops.
    localparam logic [msp_pkg::FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
    localparam logic [msp_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    typedef struct packed {
        logic [msp_pkg::PINS_W-1:0] pins;
        logic [msp_pkg::POS_W-1:0]  read_position;
    } servo_result_t;

    logic clk = 1'b0;
    logic rst_n;

    msp_item_if   item ();
    msp_result_if result ();
    msp_cfg_if    cfg ();

    multiplexed_servo_pulse_generator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predicted copy of the pulse engine and its registers.
    logic [msp_pkg::POS_W-1:0]   servo_pos [msp_pkg::NUM_SERVOS] = '{default: '0};
    logic [3:0]                  slot_idx        = '0;
    logic                        frame_idle      = 1'b0;
    logic [msp_pkg::TICKS_W-1:0] seg_ticks_left  = '0;
    logic [msp_pkg::TICKS_W-1:0] loaded_sum      = '0;
    logic [msp_pkg::TICKS_W-1:0] cfg_frame_ticks = msp_pkg::FRAME_TICKS_RST;
    logic [msp_pkg::POS_W-1:0]   cfg_min_high    = msp_pkg::MIN_HIGH_RST;
    logic [msp_pkg::POS_W-1:0]   cfg_max_high    = msp_pkg::MAX_HIGH_RST;

    servo_result_t      pending_results [$];

    int                 mismatch_count = 0;
    int                 cycle_count    = 0;
    int                 burst_left     = 0;
    int                 func_count [4] = '{default: 0};
    int                 reg_writes     = 0;
    logic [msp_pkg::PINS_W-1:0] pins_seen = '0;
    bit                 long_hold_req  = 1'b0;

    // Advance the predicted engine by one command and return its result beat.
    task automatic servo_step(input logic [msp_pkg::FUNC_W-1:0] f,
                              input logic [msp_pkg::CHANNEL_W-1:0] ch,
                              input logic [msp_pkg::POS_W-1:0] pos,
                              output servo_result_t res);
        logic [msp_pkg::POS_W-1:0] stored;
        logic                      load;
        logic [3:0]                next_slot;
        res = '0;
        load = 1'b0;
        next_slot = '0;
        // Pins reflect the levels held while this command is in effect.
        if (!frame_idle && slot_idx < msp_pkg::NUM_SERVOS &&
            servo_pos[slot_idx[msp_pkg::SLOT_W-1:0]] != '0)
            res.pins[slot_idx[msp_pkg::SLOT_W-1:0]] = 1'b1;
        case (f)
            msp_pkg::FUNC_TICK:
            begin
                if (seg_ticks_left != '0)
                    seg_ticks_left = seg_ticks_left - 1'b1;
                else if (frame_idle)
                begin
                    frame_idle = 1'b0;
                    loaded_sum = '0;
                    load = 1'b1;
                end
                else if (slot_idx + 1 < msp_pkg::NUM_SERVOS)
                begin
                    load = 1'b1;
                    next_slot = slot_idx + 1'b1;
                end
                else
                begin
                    // Idle gap is the frame remainder, saturating at zero.
                    frame_idle = 1'b1;
                    slot_idx = '0;
                    seg_ticks_left = (cfg_frame_ticks > loaded_sum) ?
                                     cfg_frame_ticks - loaded_sum : '0;
                end
                if (load)
                begin
                    slot_idx = next_slot;
                    seg_ticks_left =
                        msp_pkg::TICKS_W'(servo_pos[next_slot[msp_pkg::SLOT_W-1:0]]);
                    loaded_sum = loaded_sum +
                        msp_pkg::TICKS_W'(servo_pos[next_slot[msp_pkg::SLOT_W-1:0]]);
                end
            end
            msp_pkg::FUNC_SET:
            begin
                // Nonzero values are clamped, the lower limit taking priority.
                stored = pos;
                if (stored != '0 && stored < cfg_min_high)
                    stored = cfg_min_high;
                else if (stored != '0 && stored > cfg_max_high)
                    stored = cfg_max_high;
                if (ch < msp_pkg::NUM_SERVOS)
                    servo_pos[ch[msp_pkg::SLOT_W-1:0]] = stored;
            end
            msp_pkg::FUNC_GET:
            begin
                if (ch < msp_pkg::NUM_SERVOS)
                    res.read_position = servo_pos[ch[msp_pkg::SLOT_W-1:0]];
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic void note_mismatch(string what, logic [msp_pkg::POS_W-1:0] want,
                                          logic [msp_pkg::POS_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("Mismatch in %s at %0t ns: expected %0h, got %0h", what, $time, want, got);
    endfunction

    // Check result beats, follow register writes and predict each accepted command.
    always @(posedge clk)
    begin : monitor
        servo_result_t want;
        servo_result_t res;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                pins_seen = pins_seen | result.pins;
                if (pending_results.size() == 0)
                    note_mismatch("unexpected result beat", '0, result.pins);
                else
                begin
                    want = pending_results.pop_front();
                    if (result.pins !== want.pins)
                        note_mismatch("pins", want.pins, result.pins);
                    if (result.read_position !== want.read_position)
                        note_mismatch("read_position", want.read_position,
                                      result.read_position);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                reg_writes++;
                case (cfg.index)
                    msp_pkg::CFG_FRAME_TICKS:
                        cfg_frame_ticks = cfg.data[msp_pkg::TICKS_W-1:0];
                    msp_pkg::CFG_MIN_HIGH:    cfg_min_high = cfg.data[msp_pkg::POS_W-1:0];
                    msp_pkg::CFG_MAX_HIGH:    cfg_max_high = cfg.data[msp_pkg::POS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (item.valid && item.ready)
            begin
                func_count[item.func]++;
                servo_step(item.func, item.channel, item.position, res);
                pending_results.push_back(res);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results pending", cycle_count,
                     pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result receiver: alternates stall patterns and honours long hold requests.
    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0:       result.ready <= 1'b1;
                    1:       result.ready <= ($urandom_range(0, 1) != 0);
                    2:       result.ready <= ($urandom_range(0, 3) == 0);
                    default: result.ready <= (mode_left % 3 != 0);
                endcase
            end
        end
    end

    // Offer one command beat, in bursts separated by random gaps.
    task automatic send_cmd(input logic [msp_pkg::FUNC_W-1:0] f,
                            input logic [msp_pkg::CHANNEL_W-1:0] ch,
                            input logic [msp_pkg::POS_W-1:0] pos);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                item.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item.valid    <= 1'b1;
        item.func     <= f;
        item.channel  <= ch;
        item.position <= pos;
        do @(posedge clk); while (!item.ready);
    endtask

    task automatic write_reg(input logic [msp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [msp_pkg::CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
    endtask

    // Program all three registers; upper data bits of the byte registers are junk.
    task automatic configure(input logic [msp_pkg::TICKS_W-1:0] frame,
                             input logic [msp_pkg::POS_W-1:0] lo,
                             input logic [msp_pkg::POS_W-1:0] hi);
        logic [msp_pkg::CFG_DATA_W-1:0] data;
        write_reg(msp_pkg::CFG_FRAME_TICKS, frame);
        data = msp_pkg::CFG_DATA_W'($urandom());
        data[msp_pkg::POS_W-1:0] = lo;
        write_reg(msp_pkg::CFG_MIN_HIGH, data);
        data = msp_pkg::CFG_DATA_W'($urandom());
        data[msp_pkg::POS_W-1:0] = hi;
        write_reg(msp_pkg::CFG_MAX_HIGH, data);
        // A write to the spare index must change nothing.
        write_reg(CFG_UNUSED, msp_pkg::CFG_DATA_W'($urandom()));
        cfg.valid <= 1'b0;
    endtask

    // Stop offering commands and let every outstanding result come back.
    task automatic wait_drain();
        item.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_cmds(input int count, input int tick_pct, input int pos_max);
        logic [msp_pkg::FUNC_W-1:0]    f;
        logic [msp_pkg::CHANNEL_W-1:0] ch;
        logic [msp_pkg::POS_W-1:0]     pos;
        int                            r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < tick_pct)
                f = msp_pkg::FUNC_TICK;
            else if (r < tick_pct + (100 - tick_pct) * 6 / 10)
                f = msp_pkg::FUNC_SET;
            else if (r < 96)
                f = msp_pkg::FUNC_GET;
            else
                f = FUNC_UNUSED;
            ch = ($urandom_range(0, 3) == 0) ? msp_pkg::CHANNEL_W'($urandom_range(8, 15))
                                             : msp_pkg::CHANNEL_W'($urandom_range(0, 7));
            r = $urandom_range(0, 99);
            if (r < 10)
                pos = '0;
            else if (r < 18)
                pos = msp_pkg::POS_W'($urandom());
            else
                pos = msp_pkg::POS_W'($urandom_range(1, pos_max));
            send_cmd(f, ch, pos);
        end
    endtask

    // Reset contents, field extremes, bad channels and the spare operation.
    task automatic test_directed();
        send_cmd(msp_pkg::FUNC_GET, 4'd3, 8'hFF);
        send_cmd(msp_pkg::FUNC_TICK, 4'd0, 8'h00);
        send_cmd(msp_pkg::FUNC_TICK, 4'd15, 8'hFF);
        send_cmd(msp_pkg::FUNC_SET, 4'd0, 8'hFF);
        send_cmd(msp_pkg::FUNC_SET, 4'd7, 8'h01);
        send_cmd(msp_pkg::FUNC_SET, 4'd1, 8'h80);
        send_cmd(msp_pkg::FUNC_SET, 4'd8, 8'h4D);
        send_cmd(msp_pkg::FUNC_SET, 4'd15, 8'hFF);
        send_cmd(msp_pkg::FUNC_SET, 4'd2, 8'h00);
        send_cmd(msp_pkg::FUNC_GET, 4'd0, 8'h00);
        send_cmd(msp_pkg::FUNC_GET, 4'd7, 8'h00);
        send_cmd(msp_pkg::FUNC_GET, 4'd8, 8'h00);
        send_cmd(msp_pkg::FUNC_GET, 4'd15, 8'h00);
        send_cmd(FUNC_UNUSED, 4'd15, 8'hFF);
        send_cmd(msp_pkg::FUNC_TICK, 4'd0, 8'h00);
        send_cmd(msp_pkg::FUNC_TICK, 4'd0, 8'h00);
        wait_drain();
    endtask

    // Values below the lower limit, above and at the upper limit, and zero.
    task automatic test_clamping();
        configure(12'd20, 8'd10, 8'd200);
        send_cmd(msp_pkg::FUNC_SET, 4'd3, 8'd3);
        send_cmd(msp_pkg::FUNC_SET, 4'd4, 8'd250);
        send_cmd(msp_pkg::FUNC_SET, 4'd5, 8'd0);
        send_cmd(msp_pkg::FUNC_SET, 4'd6, 8'd200);
        send_cmd(msp_pkg::FUNC_GET, 4'd3, 8'd0);
        send_cmd(msp_pkg::FUNC_GET, 4'd4, 8'd0);
        send_cmd(msp_pkg::FUNC_GET, 4'd5, 8'd0);
        send_cmd(msp_pkg::FUNC_GET, 4'd6, 8'd0);
        wait_drain();
    endtask

    // Zero frame length: every idle gap is a single tick, so frames turn over fast.
    task automatic test_short_frames();
        configure(12'd0, 8'd1, 8'd255);
        for (int ch = 0; ch < msp_pkg::NUM_SERVOS; ch++)
            send_cmd(msp_pkg::FUNC_SET, msp_pkg::CHANNEL_W'(ch),
                     msp_pkg::POS_W'($urandom_range(1, 4)));
        random_cmds(170, 60, 4);
        wait_drain();
    endtask

    // The receiver holds off for a long stretch while commands keep coming.
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        random_cmds(60, 80, 4);
        wait_drain();
    endtask

    // Random frame length and limits, min sometimes above max.
    task automatic test_random_limits();
        configure(msp_pkg::TICKS_W'($urandom_range(1, 60)),
                  msp_pkg::POS_W'($urandom_range(1, 8)),
                  msp_pkg::POS_W'($urandom_range(1, 12)));
        random_cmds(140, 60, 12);
        wait_drain();
    endtask

    // Longest frame with both limits at their lowest, then both at their highest.
    task automatic test_limit_extremes();
        configure(12'hFFF, 8'd1, 8'd1);
        random_cmds(40, 50, 255);
        wait_drain();
        configure(12'hFFF, 8'd255, 8'd255);
        random_cmds(40, 50, 255);
        wait_drain();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        item.valid    <= 1'b0;
        item.func     <= msp_pkg::FUNC_TICK;
        item.channel  <= '0;
        item.position <= '0;
        cfg.valid     <= 1'b0;
        cfg.index     <= msp_pkg::CFG_FRAME_TICKS;
        cfg.data      <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_clamping();
        test_short_frames();
        test_backpressure();
        test_random_limits();
        test_limit_extremes();

        $display("Sent %0d ticks, %0d sets, %0d gets and %0d spare commands; %0d register writes.",
                 func_count[msp_pkg::FUNC_TICK], func_count[msp_pkg::FUNC_SET],
                 func_count[msp_pkg::FUNC_GET], func_count[FUNC_UNUSED], reg_writes);
        $display("Servo pins seen high: %b; mismatches: %0d.", pins_seen, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
